// ===== hdl/cfd_pkg.sv =====
// Shared types, codes and constants of the CRC-32 frame decoder.
package cfd_pkg;

   localparam int POS_W = 17;
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam logic [POS_W-1:0] POS_MAX       = {POS_W{1'b1}};
   localparam logic [POS_W-1:0] HEADER_BYTES  = POS_W'(10);
   localparam logic [POS_W-1:0] MIN_FRAME     = POS_W'(14);
   localparam logic [15:0]      MAX_PAYLOAD   = 16'd1024;
   localparam logic [31:0]      CRC_POLY      = 32'hEDB88320;
   localparam logic [31:0]      CRC_INIT      = 32'hFFFFFFFF;

   localparam logic       KIND_PAYLOAD = 1'b0;
   localparam logic       KIND_STATUS  = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FORMAT  = 2'd1;
   localparam logic [1:0] STATUS_VERSION = 2'd2;
   localparam logic [1:0] STATUS_CRC     = 2'd3;

   localparam logic [1:0] REG_START_FIRST  = 2'd0;
   localparam logic [1:0] REG_START_SECOND = 2'd1;
   localparam logic [1:0] REG_VERSION      = 2'd2;
   localparam logic [1:0] REG_FLAGS_MASK   = 2'd3;

   localparam logic [7:0] FLAGS_MASK_RESET = 8'hFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  payload_byte;
      logic [1:0]  status;
      logic [7:0]  opcode;
      logic [7:0]  frame_flags;
      logic [15:0] txn_id;
      logic [15:0] payload_length;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] start_byte_first;
      logic [7:0] start_byte_second;
      logic [7:0] profile_version;
      logic [7:0] allowed_flags_mask;
   } cfg_type;

endpackage

// ===== hdl/cfd_csr.sv =====
// APB register file holding the decoder's configuration.
module cfd_csr
   import cfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   logic [1:0] index;
   logic       write_en;
   logic [7:0] read_byte;

   assign index      = csr_paddr[ADDR_W-1:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte_first   <= 8'd0;
         cfg_ff.start_byte_second  <= 8'd0;
         cfg_ff.profile_version    <= 8'd0;
         cfg_ff.allowed_flags_mask <= FLAGS_MASK_RESET;
      end else if (write_en) begin
         unique case (index)
            REG_START_FIRST:  cfg_ff.start_byte_first   <= csr_pwdata[7:0];
            REG_START_SECOND: cfg_ff.start_byte_second  <= csr_pwdata[7:0];
            REG_VERSION:      cfg_ff.profile_version    <= csr_pwdata[7:0];
            REG_FLAGS_MASK:   cfg_ff.allowed_flags_mask <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_START_FIRST:  read_byte = cfg_ff.start_byte_first;
         REG_START_SECOND: read_byte = cfg_ff.start_byte_second;
         REG_VERSION:      read_byte = cfg_ff.profile_version;
         REG_FLAGS_MASK:   read_byte = cfg_ff.allowed_flags_mask;
         default:          read_byte = 8'd0;
      endcase
   end

   assign csr_prdata = {{(DATA_W-8){1'b0}}, read_byte};

endmodule

// ===== hdl/crc32_frame_decoder.sv =====
// Top level of the streaming length-prefixed frame decoder with CRC-32 check.
//
//   channel  direction  handshake              word
//   req      in         req_valid/req_ready    req_word_type (data_byte, last_byte)
//   rsp      out        rsp_valid/rsp_ready    rsp_word_type (payload byte or status)
//   csr      in/out     APB, pready always 1   four 8-bit registers at 4*i
//
// Each word is decoded in the cycle it is accepted; one word per cycle is sustained.
// The byte-wide CRC update and the status decision sit between the frame state
// and the result register, so a result appears in the cycle after its word.
// A new word is taken while the result register is empty or being emptied.
// Reset is synchronous; it clears the frame state and valid flag, resets the CSRs.
module crc32_frame_decoder
   import cfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_word_type      req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_word_type      rsp_word,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam logic [POS_W-1:0] POS_START0  = POS_W'(0);
   localparam logic [POS_W-1:0] POS_START1  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_VERSION = POS_W'(2);
   localparam logic [POS_W-1:0] POS_OPCODE  = POS_W'(3);
   localparam logic [POS_W-1:0] POS_FLAGS   = POS_W'(4);
   localparam logic [POS_W-1:0] POS_RSVD    = POS_W'(5);
   localparam logic [POS_W-1:0] POS_TID_HI  = POS_W'(6);
   localparam logic [POS_W-1:0] POS_TID_LO  = POS_W'(7);
   localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(8);
   localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(9);

   localparam int MARK_START   = 0;
   localparam int MARK_VERSION = 1;
   localparam int MARK_FORMAT  = 2;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   cfg_type cfg;

   cfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      crc_ff, crc_in;
   logic [31:0]      rx_crc_ff, rx_crc_in;
   logic [7:0]       opcode_ff, opcode_in;
   logic [7:0]       flags_ff, flags_in;
   logic [15:0]      tid_ff, tid_in;
   logic [15:0]      length_ff, length_in;
   logic [2:0]       marks_ff, marks_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic             accept;
   logic [7:0]       b;
   logic [POS_W-1:0] data_end;
   logic [POS_W-1:0] total;
   logic             in_payload;
   logic             has_result;
   logic [1:0]       status;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign b         = req_word.data_byte;
   assign data_end  = HEADER_BYTES + {1'b0, length_ff};
   assign in_payload = (pos_ff >= HEADER_BYTES) && (pos_ff < data_end);

   always_comb begin
      opcode_in = opcode_ff;
      flags_in  = flags_ff;
      tid_in    = tid_ff;
      length_in = length_ff;
      marks_in  = marks_ff;
      crc_in    = crc_ff;
      rx_crc_in = rx_crc_ff;
      unique case (pos_ff)
         POS_START0:  if (b != cfg.start_byte_first) marks_in[MARK_START] = 1'b1;
         POS_START1:  if (b != cfg.start_byte_second) marks_in[MARK_START] = 1'b1;
         POS_VERSION: if (b != cfg.profile_version) marks_in[MARK_VERSION] = 1'b1;
         POS_OPCODE:  opcode_in = b;
         POS_FLAGS: begin
            flags_in = b;
            if ((b & ~cfg.allowed_flags_mask) != 8'd0) marks_in[MARK_FORMAT] = 1'b1;
         end
         POS_RSVD:    if (b != 8'd0) marks_in[MARK_FORMAT] = 1'b1;
         POS_TID_HI:  tid_in[15:8] = b;
         POS_TID_LO:  tid_in[7:0] = b;
         POS_LEN_HI:  length_in[15:8] = b;
         POS_LEN_LO:  length_in[7:0] = b;
         default: ;
      endcase
      if (pos_ff >= POS_VERSION && (pos_ff < HEADER_BYTES || pos_ff < data_end)) begin
         crc_in = crc_byte(crc_ff, b);
      end
      if (pos_ff >= HEADER_BYTES && pos_ff >= data_end) begin
         rx_crc_in = {rx_crc_ff[23:0], b};
      end
   end

   always_comb begin
      total = (pos_ff != POS_MAX) ? pos_ff + POS_W'(1) : POS_MAX;
      if (total < MIN_FRAME || marks_in[MARK_START]) begin
         status = STATUS_FORMAT;
      end else if (marks_in[MARK_VERSION]) begin
         status = STATUS_VERSION;
      end else if (marks_in[MARK_FORMAT] || length_in > MAX_PAYLOAD) begin
         status = STATUS_FORMAT;
      end else if (total != MIN_FRAME + {1'b0, length_in}) begin
         status = STATUS_FORMAT;
      end else if ((crc_in ^ CRC_INIT) != rx_crc_in) begin
         status = STATUS_CRC;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      has_result  = 1'b0;
      rsp_word_in = '0;
      if (req_word.last_byte) begin
         has_result                 = 1'b1;
         rsp_word_in.result_kind    = KIND_STATUS;
         rsp_word_in.status         = status;
         rsp_word_in.opcode         = opcode_in;
         rsp_word_in.frame_flags    = flags_in;
         rsp_word_in.txn_id         = tid_in;
         rsp_word_in.payload_length = length_in;
      end else begin
         if (pos_ff != POS_MAX) pos_in = pos_ff + POS_W'(1);
         if (in_payload) begin
            has_result               = 1'b1;
            rsp_word_in.result_kind  = KIND_PAYLOAD;
            rsp_word_in.payload_byte = b;
         end
      end
      if (accept && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept && has_result) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_word.last_byte)) begin
         pos_ff    <= '0;
         crc_ff    <= CRC_INIT;
         rx_crc_ff <= '0;
         opcode_ff <= '0;
         flags_ff  <= '0;
         tid_ff    <= '0;
         length_ff <= '0;
         marks_ff  <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         rx_crc_ff <= rx_crc_in;
         opcode_ff <= opcode_in;
         flags_ff  <= flags_in;
         tid_ff    <= tid_in;
         length_ff <= length_in;
         marks_ff  <= marks_in;
      end
   end

endmodule

// ===== hdl/cfd_checker.sv =====
// Port-level assertions for the frame decoder and their binding to the top level.
module cfd_checker
   import cfd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rsp_word_type      rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("Stalled result word changed or dropped.");

   a_no_result_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result word present right after reset.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Input stalled while the result register is empty.");

   a_payload_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.result_kind == KIND_PAYLOAD |->
         rsp_word.status == STATUS_OK && rsp_word.opcode == 8'd0 &&
         rsp_word.frame_flags == 8'd0 && rsp_word.txn_id == 16'd0 &&
         rsp_word.payload_length == 16'd0)
      else $error("Payload word carries header fields.");

   a_ok_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.result_kind == KIND_STATUS && rsp_word.status == STATUS_OK
         |-> rsp_word.payload_length <= MAX_PAYLOAD && rsp_word.payload_byte == 8'd0)
      else $error("Frame reported ok with an oversized payload length.");

endmodule

bind crc32_frame_decoder cfd_checker u_cfd_checker (.*);

// ===== verif/tb_crc32_frame_decoder.sv =====
// Testbench for the CRC-32 frame decoder: directed and random frames checked against a predictor.
`timescale 1ns / 1ps

module tb_crc32_frame_decoder;
   import cfd_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int RESULT_LATENCY = 4;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_PHASES = 5;
   localparam int BYTES_PER_PHASE = 40;

   localparam logic [2:0] ERR_START   = 3'b001;
   localparam logic [2:0] ERR_VERSION = 3'b010;
   localparam logic [2:0] ERR_HEADER  = 3'b100;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_word_type      req_word;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_word_type      rsp_word;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   cfg_type      decoder_cfg;
   logic [16:0]  frame_position;
   logic [31:0]  frame_crc;
   logic [31:0]  trailer_crc;
   logic [7:0]   frame_opcode;
   logic [7:0]   frame_flag_bits;
   logic [15:0]  frame_tid;
   logic [15:0]  frame_pay_len;
   logic [2:0]   frame_errors;

   rsp_word_type expected_words[$];
   logic [7:0]   frame_buffer[$];

   int unsigned  sender_gap_max;
   int unsigned  receiver_gap_max;
   bit           long_hold_request;
   int unsigned  failure_count;
   int unsigned  bytes_accepted;
   int unsigned  frames_sent;
   int unsigned  payload_seen;
   int unsigned  status_tally[4];

   crc32_frame_decoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] value);
      logic [31:0] c;
      int i;
      c = crc ^ {24'd0, value};
      for (i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void clear_frame_state();
      frame_position = '0;
      frame_crc = CRC_INIT;
      trailer_crc = '0;
      frame_opcode = '0;
      frame_flag_bits = '0;
      frame_tid = '0;
      frame_pay_len = '0;
      frame_errors = '0;
   endfunction

   function automatic void predict_word(logic [7:0] value, logic last);
      int unsigned pos;
      int unsigned data_end;
      int unsigned total;
      rsp_word_type result;
      pos = frame_position;
      data_end = HEADER_BYTES + frame_pay_len;
      case (pos)
         0: if (value != decoder_cfg.start_byte_first) frame_errors |= ERR_START;
         1: if (value != decoder_cfg.start_byte_second) frame_errors |= ERR_START;
         2: if (value != decoder_cfg.profile_version) frame_errors |= ERR_VERSION;
         3: frame_opcode = value;
         4: begin
            frame_flag_bits = value;
            if ((value & ~decoder_cfg.allowed_flags_mask) != 8'd0) frame_errors |= ERR_HEADER;
         end
         5: if (value != 8'd0) frame_errors |= ERR_HEADER;
         6: frame_tid[15:8] = value;
         7: frame_tid[7:0] = value;
         8: frame_pay_len[15:8] = value;
         9: frame_pay_len[7:0] = value;
         default: ;
      endcase
      if (pos >= 2 && (pos < HEADER_BYTES || pos < data_end)) begin
         frame_crc = crc32_update(frame_crc, value);
      end
      if (pos >= HEADER_BYTES && pos >= data_end) begin
         trailer_crc = {trailer_crc[23:0], value};
      end
      result = '0;
      if (!last) begin
         if (pos < POS_MAX) frame_position = 17'(pos + 1);
         if (pos >= HEADER_BYTES && pos < data_end) begin
            result.result_kind = KIND_PAYLOAD;
            result.payload_byte = value;
            expected_words.push_back(result);
         end
         return;
      end
      total = (pos < POS_MAX) ? pos + 1 : POS_MAX;
      result.result_kind = KIND_STATUS;
      if (total < MIN_FRAME || (frame_errors & ERR_START) != 0) begin
         result.status = STATUS_FORMAT;
      end else if ((frame_errors & ERR_VERSION) != 0) begin
         result.status = STATUS_VERSION;
      end else if ((frame_errors & ERR_HEADER) != 0) begin
         result.status = STATUS_FORMAT;
      end else if (frame_pay_len > MAX_PAYLOAD) begin
         result.status = STATUS_FORMAT;
      end else if (total != MIN_FRAME + frame_pay_len) begin
         result.status = STATUS_FORMAT;
      end else if ((frame_crc ^ CRC_INIT) != trailer_crc) begin
         result.status = STATUS_CRC;
      end else begin
         result.status = STATUS_OK;
      end
      result.opcode = frame_opcode;
      result.frame_flags = frame_flag_bits;
      result.txn_id = frame_tid;
      result.payload_length = frame_pay_len;
      expected_words.push_back(result);
      clear_frame_state();
   endfunction

   function automatic void check_field(string field_name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field_name, want, got);
         failure_count++;
      end
   endfunction

   function automatic void check_result(rsp_word_type got);
      rsp_word_type want;
      if (got.result_kind == KIND_STATUS) begin
         status_tally[got.status]++;
      end else begin
         payload_seen++;
      end
      if (expected_words.size() == 0) begin
         $error("result word %h arrived with nothing expected", got);
         failure_count++;
         return;
      end
      want = expected_words.pop_front();
      check_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
      check_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
      check_field("status", 16'(want.status), 16'(got.status));
      check_field("opcode", 16'(want.opcode), 16'(got.opcode));
      check_field("frame_flags", 16'(want.frame_flags), 16'(got.frame_flags));
      check_field("txn_id", want.txn_id, got.txn_id);
      check_field("payload_length", want.payload_length, got.payload_length);
   endfunction

   initial begin : result_receiver
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            check_result(rsp_word);
            stall_left = $urandom_range(0, receiver_gap_max);
         end
         @(negedge clock);
         if (long_hold_request) begin
            stall_left = LONG_HOLD_CYCLES;
            long_hold_request = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $error("no word accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
   end

   task automatic send_byte(input logic [7:0] value, input logic last);
      int unsigned gap;
      gap = $urandom_range(0, sender_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word <= {value, last};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_word(value, last);
      bytes_accepted++;
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_buffer.size(); i++) begin
         send_byte(frame_buffer[i], i == frame_buffer.size() - 1);
      end
      frames_sent++;
   endtask

   function automatic void build_frame(logic [7:0] first_byte, logic [7:0] second_byte,
                                       logic [7:0] version, logic [7:0] opcode,
                                       logic [7:0] flags, logic [7:0] reserved,
                                       logic [15:0] tid, logic [15:0] length,
                                       int unsigned body);
      logic [31:0] crc;
      int unsigned i;
      frame_buffer.delete();
      frame_buffer.push_back(first_byte);
      frame_buffer.push_back(second_byte);
      frame_buffer.push_back(version);
      frame_buffer.push_back(opcode);
      frame_buffer.push_back(flags);
      frame_buffer.push_back(reserved);
      frame_buffer.push_back(tid[15:8]);
      frame_buffer.push_back(tid[7:0]);
      frame_buffer.push_back(length[15:8]);
      frame_buffer.push_back(length[7:0]);
      for (i = 0; i < body; i++) begin
         frame_buffer.push_back(8'($urandom_range(0, 255)));
      end
      crc = CRC_INIT;
      for (i = 2; i < frame_buffer.size(); i++) begin
         crc = crc32_update(crc, frame_buffer[i]);
      end
      crc = crc ^ CRC_INIT;
      frame_buffer.push_back(crc[31:24]);
      frame_buffer.push_back(crc[23:16]);
      frame_buffer.push_back(crc[15:8]);
      frame_buffer.push_back(crc[7:0]);
   endfunction

   function automatic void good_frame(logic [7:0] opcode, logic [7:0] flags,
                                      logic [15:0] tid, logic [15:0] length);
      build_frame(decoder_cfg.start_byte_first, decoder_cfg.start_byte_second,
                  decoder_cfg.profile_version, opcode, flags, 8'h00, tid, length,
                  32'(length));
   endfunction

   function automatic void truncate_frame(int unsigned keep);
      while (frame_buffer.size() > keep) void'(frame_buffer.pop_back());
   endfunction

   task automatic csr_access(input logic write, input logic [1:0] index,
                             input logic [7:0] value, output logic [DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= ADDR_W'(4 * index);
      csr_pwdata <= DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_register(input logic [1:0] index, input logic [7:0] want);
      logic [DATA_W-1:0] rdata;
      csr_access(1'b0, index, 8'h00, rdata);
      if (rdata[7:0] !== want) begin
         $error("register %0d readback: expected %0h, got %0h", index, want, rdata[7:0]);
         failure_count++;
      end
   endtask

   task automatic set_register(input logic [1:0] index, input logic [7:0] value);
      logic [DATA_W-1:0] unused;
      csr_access(1'b1, index, value, unused);
      case (index)
         REG_START_FIRST:  decoder_cfg.start_byte_first = value;
         REG_START_SECOND: decoder_cfg.start_byte_second = value;
         REG_VERSION:      decoder_cfg.profile_version = value;
         REG_FLAGS_MASK:   decoder_cfg.allowed_flags_mask = value;
         default: ;
      endcase
      check_register(index, value);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY) @(posedge clock);
   endtask

   task automatic apply_config(input logic [7:0] first_byte, input logic [7:0] second_byte,
                               input logic [7:0] version, input logic [7:0] mask);
      wait_idle();
      set_register(REG_START_FIRST, first_byte);
      set_register(REG_START_SECOND, second_byte);
      set_register(REG_VERSION, version);
      set_register(REG_FLAGS_MASK, mask);
   endtask

   task automatic test_register_reset_values();
      check_register(REG_START_FIRST, 8'h00);
      check_register(REG_START_SECOND, 8'h00);
      check_register(REG_VERSION, 8'h00);
      check_register(REG_FLAGS_MASK, FLAGS_MASK_RESET);
   endtask

   task automatic test_directed_frames();
      apply_config(8'hA5, 8'h5A, 8'h01, 8'h0F);
      good_frame(8'h00, 8'h00, 16'h0000, 16'd0);
      send_frame();
      good_frame(8'hFF, 8'h0F, 16'hFFFF, 16'd3);
      send_frame();
      build_frame(8'hA4, 8'h5A, 8'h01, 8'h10, 8'h01, 8'h00, 16'h1234, 16'd1, 1);
      send_frame();
      build_frame(8'hA5, 8'hDA, 8'h01, 8'h11, 8'h02, 8'h00, 16'h1235, 16'd1, 1);
      send_frame();
      build_frame(8'hA5, 8'h5A, 8'h81, 8'h12, 8'h03, 8'h00, 16'h1236, 16'd1, 1);
      send_frame();
      // A version error outranks a bad flags field, and a start error outranks both.
      build_frame(8'hA5, 8'h5A, 8'h02, 8'h13, 8'hF0, 8'h00, 16'h1237, 16'd1, 1);
      send_frame();
      build_frame(8'h00, 8'h5A, 8'h02, 8'h14, 8'hF0, 8'h00, 16'h1238, 16'd1, 1);
      send_frame();
      build_frame(8'hA5, 8'h5A, 8'h01, 8'h15, 8'h80, 8'h00, 16'h1239, 16'd1, 1);
      send_frame();
      build_frame(8'hA5, 8'h5A, 8'h01, 8'h16, 8'h01, 8'hFF, 16'h123A, 16'd1, 1);
      send_frame();
      good_frame(8'h17, 8'h04, 16'h8000, 16'd2);
      frame_buffer[frame_buffer.size() - 1] ^= 8'h01;
      send_frame();
      good_frame(8'h18, 8'h08, 16'h0001, 16'd2);
      frame_buffer[10] ^= 8'h80;
      send_frame();
      // Oversized length with the frame cut short inside its payload.
      build_frame(8'hA5, 8'h5A, 8'h01, 8'h19, 8'h00, 8'h00, 16'h00FF, 16'hFFFF, 6);
      send_frame();
      send_byte(8'hA5, 1'b1);
      frames_sent++;
      good_frame(8'h1A, 8'h00, 16'hFF00, 16'd0);
      truncate_frame(9);
      send_frame();
      good_frame(8'h1B, 8'h00, 16'h0F0F, 16'd5);
      truncate_frame(12);
      send_frame();
      good_frame(8'h1C, 8'h00, 16'hF0F0, 16'd2);
      repeat (3) frame_buffer.push_back(8'($urandom_range(0, 255)));
      send_frame();
      build_frame(8'hA5, 8'h5A, 8'h01, 8'h1D, 8'h00, 8'h00, 16'h5555, 16'd1, 3);
      send_frame();
   endtask

   task automatic test_payload_limits();
      apply_config(8'h00, 8'h00, 8'h00, 8'h00);
      good_frame(8'h20, 8'h00, 16'hAAAA, MAX_PAYLOAD);
      send_frame();
      build_frame(8'h00, 8'h00, 8'h00, 8'h21, 8'h01, 8'h00, 16'h5555, 16'd4, 4);
      send_frame();
      apply_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      build_frame(8'hFF, 8'hFF, 8'hFF, 8'h22, 8'hFF, 8'h00, 16'h7FFF,
                  MAX_PAYLOAD + 16'd1, 4);
      send_frame();
      good_frame(8'h23, 8'hFF, 16'h0000, 16'd4);
      send_frame();
   endtask

   task automatic test_output_backpressure();
      int i;
      wait_idle();
      sender_gap_max = 0;
      receiver_gap_max = 2;
      long_hold_request = 1'b1;
      for (i = 0; i < 3; i++) begin
         good_frame(8'h40 + 8'(i), 8'h00, 16'(i), 16'd40);
         send_frame();
      end
   endtask

   task automatic send_random_frame();
      logic [7:0]  opcode;
      logic [7:0]  flags;
      logic [7:0]  mask;
      logic [15:0] tid;
      logic [15:0] length;
      int unsigned extra;
      mask = decoder_cfg.allowed_flags_mask;
      opcode = 8'($urandom_range(0, 255));
      flags = 8'($urandom_range(0, 255)) & mask;
      tid = 16'($urandom_range(0, 65535));
      length = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 24));
      if ($urandom_range(0, 99) < 65) begin
         good_frame(opcode, flags, tid, length);
      end else begin
         case ($urandom_range(0, 9))
            0: build_frame(decoder_cfg.start_byte_first ^ 8'($urandom_range(1, 255)),
                           decoder_cfg.start_byte_second, decoder_cfg.profile_version,
                           opcode, flags, 8'h00, tid, length, length);
            1: build_frame(decoder_cfg.start_byte_first,
                           decoder_cfg.start_byte_second ^ 8'($urandom_range(1, 255)),
                           decoder_cfg.profile_version, opcode, flags, 8'h00, tid,
                           length, length);
            2: build_frame(decoder_cfg.start_byte_first, decoder_cfg.start_byte_second,
                           decoder_cfg.profile_version ^ 8'($urandom_range(1, 255)),
                           opcode, flags, 8'h00, tid, length, length);
            3: build_frame(decoder_cfg.start_byte_first, decoder_cfg.start_byte_second,
                           decoder_cfg.profile_version, opcode,
                           flags | (~mask & 8'($urandom_range(1, 255))), 8'h00, tid,
                           length, length);
            4: build_frame(decoder_cfg.start_byte_first, decoder_cfg.start_byte_second,
                           decoder_cfg.profile_version, opcode, flags,
                           8'($urandom_range(1, 255)), tid, length, length);
            5: begin
               good_frame(opcode, flags, tid, length);
               frame_buffer[$urandom_range(0, frame_buffer.size() - 1)] ^=
                  8'($urandom_range(1, 255));
            end
            6: begin
               good_frame(opcode, flags, tid, length);
               truncate_frame($urandom_range(1, frame_buffer.size() - 1));
            end
            7: begin
               good_frame(opcode, flags, tid, length);
               extra = $urandom_range(1, 4);
               repeat (extra) frame_buffer.push_back(8'($urandom_range(0, 255)));
            end
            8: begin
               if ($urandom_range(0, 1) == 0) begin
                  build_frame(decoder_cfg.start_byte_first, decoder_cfg.start_byte_second,
                              decoder_cfg.profile_version, opcode, flags, 8'h00, tid,
                              length, length + $urandom_range(1, 3));
               end else begin
                  build_frame(decoder_cfg.start_byte_first, decoder_cfg.start_byte_second,
                              decoder_cfg.profile_version, opcode, flags, 8'h00, tid,
                              16'($urandom_range(MAX_PAYLOAD + 1, 65535)),
                              $urandom_range(0, 12));
               end
            end
            default: begin
               frame_buffer.delete();
               extra = $urandom_range(1, 20);
               repeat (extra) frame_buffer.push_back(8'($urandom_range(0, 255)));
            end
         endcase
      end
      send_frame();
   endtask

   task automatic test_random_frames();
      int phase;
      int unsigned phase_start;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 3)
            0: apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            1: apply_config(8'h00, 8'h00, 8'h00, 8'h00);
            default: apply_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
         endcase
         sender_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
         receiver_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
         phase_start = bytes_accepted;
         while (bytes_accepted - phase_start < BYTES_PER_PHASE) begin
            send_random_frame();
         end
      end
   endtask

   initial begin : main_sequence
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sender_gap_max = 11;
      receiver_gap_max = 11;
      long_hold_request = 1'b0;
      failure_count = 0;
      bytes_accepted = 0;
      frames_sent = 0;
      payload_seen = 0;
      status_tally = '{default: 0};
      decoder_cfg.start_byte_first = 8'h00;
      decoder_cfg.start_byte_second = 8'h00;
      decoder_cfg.profile_version = 8'h00;
      decoder_cfg.allowed_flags_mask = FLAGS_MASK_RESET;
      clear_frame_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_reset_values();
      test_directed_frames();
      test_payload_limits();
      test_output_backpressure();
      sender_gap_max = 11;
      receiver_gap_max = 11;
      test_random_frames();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d frames of %0d bytes sent, %0d payload words returned",
               frames_sent, bytes_accepted, payload_seen);
      $display("summary: status words ok %0d, format %0d, version %0d, crc %0d",
               status_tally[STATUS_OK], status_tally[STATUS_FORMAT],
               status_tally[STATUS_VERSION], status_tally[STATUS_CRC]);
      if (failure_count == 0 && expected_words.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/cfd_pkg.sv
hdl/cfd_csr.sv
hdl/crc32_frame_decoder.sv
hdl/cfd_checker.sv
verif/tb_crc32_frame_decoder.sv
